/* hdl/mtwg_pkg.sv */
// shared constants and types of the mt19937 word generator
package mtwg_pkg;

    localparam int unsigned STATE_WORDS  = 624;
    localparam int unsigned SHIFT_OFFSET = 397;
    localparam int unsigned IDX_W        = 10;

    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(STATE_WORDS - 1);
    localparam logic [IDX_W-1:0] FAR_UP    = IDX_W'(SHIFT_OFFSET);
    localparam logic [IDX_W-1:0] FAR_DOWN  = IDX_W'(STATE_WORDS - SHIFT_OFFSET);

    localparam logic [31:0] SEED_RESET   = 32'd5489;
    localparam logic [31:0] SEED_MULT    = 32'd1812433253;
    localparam logic [31:0] TWIST_MATRIX = 32'h9908b0df;
    localparam logic [31:0] HIGH_BIT     = 32'h80000000;
    localparam logic [31:0] LOW_BITS     = 32'h7fffffff;
    localparam logic [31:0] TEMPER_B     = 32'h9d2c5680;
    localparam logic [31:0] TEMPER_C     = 32'hefc60000;

    // register index of the seed
    localparam logic REG_SEED = 1'b0;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_FILL  = 4'b0010,
        ST_READ  = 4'b0100,
        ST_WRITE = 4'b1000
    } t_state;

endpackage

/* hdl/mersenne_twister_word_generator_top.sv */
// mt19937 word generator top level: control, state memory and config port
//
// usage
// - input channel (i_valid / o_stall, payload i_restart): each transfer asks
//   for one tempered 32-bit word; i_restart = 1 reseeds the state first
// - output channel (o_valid / i_stall, payload o_random_word): one transfer
//   per request, in request order
// - config port: apb-style, seed register at byte address 0, pready tied high
// - the 624-word state sits in a memory with two read ports and one write
//   port; each request twists one word in place: a normal request reads
//   word k+1 and the far word on acceptance, then writes back and tempers
// - a request with restart, or the first one after reset, first fills the
//   memory from the seed one word per cycle through the seed multiplier:
//   all 624 words, then the read state and the write state
// - the result sits in an output register; the next request is accepted
//   while it waits; a stalled result holds, and the write-back waits for it
// - reset: seed returns to 5489 and the store is marked unseeded; the memory
//   is not cleared
module mersenne_twister_word_generator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_restart,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_random_word,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned IW = mtwg_pkg::IDX_W;

    mtwg_pkg::t_state r_state;
    mtwg_pkg::t_state n_state;

    logic [31:0]   r_seed;
    logic          r_seeded;
    logic [IW-1:0] r_idx;
    logic [IW-1:0] r_cnt;
    logic [31:0]   r_prev;
    logic [31:0]   r_cur;
    logic          r_out_valid;
    logic          n_out_valid;
    logic [31:0]   r_out_word;

    logic [31:0]   mem [mtwg_pkg::STATE_WORDS];
    logic [31:0]   r_rd_nxt;
    logic [31:0]   r_rd_far;

    logic          accept;
    logic          need_fill;
    logic          rd_en;
    logic [IW-1:0] rd_addr_nxt;
    logic [IW-1:0] rd_addr_far;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [31:0]   wr_data;
    logic [31:0]   fill_word;
    logic [31:0]   fill_mix;
    logic [31:0]   twisted;
    logic [31:0]   tempered;
    logic          write_go;
    logic          cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;
    assign prdata    = (paddr[2] == mtwg_pkg::REG_SEED) ? r_seed : 32'd0;

    assign o_stall       = (r_state != mtwg_pkg::ST_IDLE);
    assign o_valid       = r_out_valid;
    assign o_random_word = r_out_word;

    assign accept    = i_valid & ~o_stall;
    assign need_fill = i_restart | ~r_seeded;
    assign write_go  = (r_state == mtwg_pkg::ST_WRITE) & (~r_out_valid | ~i_stall);

    // addresses of word k+1 and of the word SHIFT_OFFSET ahead, both mod 624
    always_comb begin
        rd_addr_nxt = (r_idx == mtwg_pkg::LAST_IDX) ? '0 : r_idx + IW'(1);
        if (r_idx < mtwg_pkg::FAR_DOWN) begin
            rd_addr_far = r_idx + mtwg_pkg::FAR_UP;
        end else begin
            rd_addr_far = r_idx - mtwg_pkg::FAR_DOWN;
        end
    end

    assign rd_en = (accept & ~need_fill) | (r_state == mtwg_pkg::ST_READ);

    assign fill_mix  = r_prev ^ (r_prev >> 30);
    assign fill_word = (r_cnt == '0) ? r_seed
                                     : 32'(mtwg_pkg::SEED_MULT * fill_mix) + 32'(r_cnt);

    mtwg_word_unit u_word (
        .i_cur      (r_cur),
        .i_nxt      (r_rd_nxt),
        .i_far      (r_rd_far),
        .o_twisted  (twisted),
        .o_tempered (tempered)
    );

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_idx;
        wr_data = twisted;
        if (r_state == mtwg_pkg::ST_FILL) begin
            wr_en   = 1'b1;
            wr_addr = r_cnt;
            wr_data = fill_word;
        end else if (write_go) begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_nxt <= mem[rd_addr_nxt];
            r_rd_far <= mem[rd_addr_far];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mtwg_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = need_fill ? mtwg_pkg::ST_FILL : mtwg_pkg::ST_WRITE;
                end
            end
            mtwg_pkg::ST_FILL: begin
                if (r_cnt == mtwg_pkg::LAST_IDX) begin
                    n_state = mtwg_pkg::ST_READ;
                end
            end
            mtwg_pkg::ST_READ: begin
                n_state = mtwg_pkg::ST_WRITE;
            end
            mtwg_pkg::ST_WRITE: begin
                if (write_go) begin
                    n_state = mtwg_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mtwg_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (write_go) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid & ~i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mtwg_pkg::ST_IDLE;
            r_seed      <= mtwg_pkg::SEED_RESET;
            r_seeded    <= 1'b0;
            r_idx       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (cfg_write && paddr[2] == mtwg_pkg::REG_SEED) begin
                r_seed <= pwdata;
            end
            if (accept && need_fill) begin
                r_cnt <= '0;
            end else if (r_state == mtwg_pkg::ST_FILL) begin
                r_cnt <= r_cnt + IW'(1);
                if (r_cnt == mtwg_pkg::LAST_IDX) begin
                    r_idx    <= '0;
                    r_seeded <= 1'b1;
                end
            end
            if (write_go) begin
                r_idx <= (r_idx == mtwg_pkg::LAST_IDX) ? '0 : r_idx + IW'(1);
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == mtwg_pkg::ST_FILL) begin
            r_prev <= fill_word;
            // word 0 is the first one twisted after a fill
            if (r_cnt == '0) begin
                r_cur <= fill_word;
            end
        end
        if (write_go) begin
            // old word k+1 becomes the current word of the next request
            r_cur      <= r_rd_nxt;
            r_out_word <= tempered;
        end
    end

endmodule

/* hdl/mtwg_word_unit.sv */
// twist of one state word and tempering of the result
module mtwg_word_unit (
    input  logic [31:0] i_cur,
    input  logic [31:0] i_nxt,
    input  logic [31:0] i_far,
    output logic [31:0] o_twisted,
    output logic [31:0] o_tempered
);

    logic [31:0] y;
    logic [31:0] t0;
    logic [31:0] t1;
    logic [31:0] t2;

    always_comb begin
        y = (i_cur & mtwg_pkg::HIGH_BIT) | (i_nxt & mtwg_pkg::LOW_BITS);
        o_twisted = i_far ^ (y >> 1);
        if (y[0]) begin
            o_twisted = o_twisted ^ mtwg_pkg::TWIST_MATRIX;
        end
        t0 = o_twisted ^ (o_twisted >> 11);
        t1 = t0 ^ ((t0 << 7) & mtwg_pkg::TEMPER_B);
        t2 = t1 ^ ((t1 << 15) & mtwg_pkg::TEMPER_C);
        o_tempered = t2 ^ (t2 >> 18);
    end

endmodule

/* hdl/mtwg_checker.sv */
// port-level checker of the mt19937 word generator and its bind
module mtwg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_random_word,
    input logic        pready
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_random_word))
        else $error("stalled result changed");

    // an accepted request leaves the block busy in the cycle after it
    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("not busy after input transfer");

    // a new result only comes out of a busy cycle
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result appeared without work");

    // a stalled result blocks the finish of the next request
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall && o_stall |=> o_valid)
        else $error("result lost while stalled");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");

endmodule

bind mersenne_twister_word_generator_top mtwg_checker u_mtwg_checker (.*);
